[design/lta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lta_pkg: shared definitions for the LED twinkle alpha block
// Field widths, ramp constants, reciprocals, register indexes and shared types.
// ----------------------------------------------------------------------------
package lta_pkg;

    // field widths
    localparam int IDX_W      = 10;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int RATE_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // cycle length: 60000 * 1024 < 2^26
    localparam int LEN_W      = 26;
    localparam int DIV_CNT_W  = $clog2(LEN_W);

    // one remainder stage per dividend bit
    localparam int MOD_STAGES = TIME_W;
    // accept to result strobe, in clock edges
    localparam int LATENCY    = MOD_STAGES + 6;

    localparam logic [TIME_W-1:0]  SPREAD_PRIME  = 32'd179426323;
    localparam logic [RATE_W-1:0]  MS_PER_MINUTE = 16'd60000;
    localparam logic [RATE_W-1:0]  DEFAULT_RATE  = 16'd300;
    localparam logic [COUNT_W-1:0] MAX_PIXELS    = 11'd1024;

    // ramp timing in ms
    localparam int BRIGHTEN_MS = 100;
    localparam int DIM_MS      = 1000;
    localparam int RAMP_END_MS = BRIGHTEN_MS + DIM_MS;
    localparam int RAMP_W      = 11;

    // ramp factor (phase or end - phase) is at most DIM_MS
    localparam int FACTOR_W    = 10;
    // factor * alpha <= 1000 * 255
    localparam int SCALED_W    = 18;
    // floor(x / D) == (x * ceil(2^28 / D)) >> 28 for every x below 2^18
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 28;
    localparam int WIDE_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_RISE = 22'd2684355;
    localparam logic [RECIP_W-1:0] RECIP_FALL = 22'd268436;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT = 3'd0,
        CFG_RATE        = 3'd1,
        CFG_COLOR_RED   = 3'd2,
        CFG_COLOR_GREEN = 3'd3,
        CFG_COLOR_BLUE  = 3'd4,
        CFG_COLOR_ALPHA = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN
    } t_div_state;

    // sideband that rides along the remainder pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             on_strip;
    } t_tag;

endpackage

[design/lta_len_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lta_len_div: cycle length divider
// Bit-serial restoring division of 60000 * pixel count by the twinkle rate.
// ----------------------------------------------------------------------------
module lta_len_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_recalc,
    input  logic [lta_pkg::COUNT_W-1:0] i_pixel_count,
    input  logic [lta_pkg::RATE_W-1:0]  i_rate,
    output logic                        o_busy,
    output logic [lta_pkg::LEN_W-1:0]   o_cycle_len
);
    import lta_pkg::*;

    t_div_state           r_state, n_state;
    logic [LEN_W-1:0]     r_quo;      // dividend bits out, quotient bits in
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0]     r_len;

    logic [RATE_W-1:0] rate_eff;
    logic [LEN_W-1:0]  num_load;
    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   rem_diff;
    logic              take;
    logic              last;
    logic [LEN_W-1:0]  quo_final;

    assign rate_eff  = (i_rate == '0) ? DEFAULT_RATE : i_rate;
    assign num_load  = LEN_W'(MS_PER_MINUTE) * LEN_W'(i_pixel_count);
    assign rem_sh    = {r_rem, r_quo[LEN_W-1]};
    assign take      = rem_sh >= {1'b0, r_den};
    assign rem_diff  = rem_sh - {1'b0, r_den};
    assign last      = r_cnt == DIV_CNT_W'(LEN_W - 1);
    assign quo_final = {r_quo[LEN_W-2:0], take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // a fresh write restarts the division with the new values
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_recalc) n_state = DIV_LOAD;
            end
            DIV_LOAD: begin
                n_state = i_recalc ? DIV_LOAD : DIV_RUN;
            end
            DIV_RUN: begin
                if (i_recalc) begin
                    n_state = DIV_LOAD;
                end else if (last) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_LOAD) begin
            r_quo <= num_load;
            r_den <= rate_eff;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == DIV_RUN) begin
            r_quo <= quo_final;
            r_rem <= take ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_len <= (quo_final == '0) ? LEN_W'(1) : quo_final;
            end
        end
    end

    assign o_busy      = r_state != DIV_IDLE;
    assign o_cycle_len = r_len;

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_IDLE) |-> (r_len != '0))
        else $error("cycle length zero while idle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN) |-> (r_rem < r_den && r_cnt < DIV_CNT_W'(LEN_W)))
        else $error("divider remainder or step count out of range");

endmodule

[design/lta_mod_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lta_mod_pipe: pipelined remainder
// One restoring compare-subtract per stage, one dividend bit per stage.
// ----------------------------------------------------------------------------
module lta_mod_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  lta_pkg::t_tag              i_tag,
    input  logic [lta_pkg::TIME_W-1:0] i_dividend,
    input  logic [lta_pkg::LEN_W-1:0]  i_len,
    output logic                       o_valid,
    output lta_pkg::t_tag              o_tag,
    output logic [lta_pkg::LEN_W-1:0]  o_phase
);
    import lta_pkg::*;

    logic              r_vld [MOD_STAGES];
    t_tag              r_tag [MOD_STAGES];
    logic [TIME_W-1:0] r_dvd [MOD_STAGES];
    logic [LEN_W-1:0]  r_rem [MOD_STAGES];

    for (genvar g = 0; g < MOD_STAGES; g++) begin : g_stage
        logic              vld_in;
        t_tag              tag_in;
        logic [TIME_W-1:0] dvd_in;
        logic [LEN_W-1:0]  rem_in;
        logic [LEN_W:0]    rem_sh;
        logic [LEN_W:0]    rem_diff;
        logic              take;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign tag_in = i_tag;
            assign dvd_in = i_dividend;
            assign rem_in = '0;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign tag_in = r_tag[g-1];
            assign dvd_in = r_dvd[g-1];
            assign rem_in = r_rem[g-1];
        end

        // rem_in < len, so the shifted value stays below 2 * len
        assign rem_sh   = {rem_in, dvd_in[TIME_W-1]};
        assign take     = rem_sh >= {1'b0, i_len};
        assign rem_diff = rem_sh - {1'b0, i_len};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (vld_in) begin
                r_tag[g] <= tag_in;
                r_dvd[g] <= {dvd_in[TIME_W-2:0], 1'b0};
                r_rem[g] <= take ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            end
        end
    end

    assign o_valid = r_vld[MOD_STAGES-1];
    assign o_tag   = r_tag[MOD_STAGES-1];
    assign o_phase = r_rem[MOD_STAGES-1];

    a_valid_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##MOD_STAGES o_valid)
        else $error("item lost in remainder pipeline");

    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, MOD_STAGES))
        else $error("remainder pipeline produced an item from nothing");

endmodule

[design/led_twinkle_alpha_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_twinkle_alpha_top: twinkle alpha for one pixel of an LED strip
// Per-pixel phase, remainder by cycle length and rising/falling alpha ramp.
// ----------------------------------------------------------------------------
// Usage: one pixel per clock while busy is low. An item is taken on every
// edge with start high and busy low; its result appears on o_done for
// exactly one cycle, in order, and the receiver cannot hold it off. The
// result path is the 32-stage remainder pipeline (one stage per time-sum
// bit) plus six stages for the spread multiply, the sum, the ramp select,
// the two alpha multiplies and the output register. busy is high after reset
// and after each transfer to the pixel count or the twinkle rate register: a
// bit-serial divider then works out the cycle length (a load state, then one
// quotient bit a cycle). Colour writes cost nothing. The config port is always
// ready; registers are only to be written with no pixels in flight.
// ----------------------------------------------------------------------------
module led_twinkle_alpha_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel command
    input  logic                           start,
    output logic                           busy,
    input  logic [lta_pkg::IDX_W-1:0]      i_pixel_index,
    input  logic [lta_pkg::TIME_W-1:0]     i_frame_time,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lta_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // result
    output logic                           o_done,
    output logic [lta_pkg::IDX_W-1:0]      o_pixel_out,
    output logic                           o_lit,
    output logic [lta_pkg::CHAN_W-1:0]     o_out_red,
    output logic [lta_pkg::CHAN_W-1:0]     o_out_green,
    output logic [lta_pkg::CHAN_W-1:0]     o_out_blue,
    output logic [lta_pkg::CHAN_W-1:0]     o_out_alpha
);
    import lta_pkg::*;

    // ---------------------------------------------------------------- config
    logic [COUNT_W-1:0] r_pixel_count;
    logic [RATE_W-1:0]  r_rate;
    logic [CHAN_W-1:0]  r_color_red;
    logic [CHAN_W-1:0]  r_color_green;
    logic [CHAN_W-1:0]  r_color_blue;
    logic [CHAN_W-1:0]  r_color_alpha;

    logic               cfg_we;
    logic               recalc;
    logic [COUNT_W-1:0] count_eff;
    logic               accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    // only count and rate feed the cycle length
    assign recalc      = cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_PIXEL_COUNT ||
                                    t_cfg_idx'(i_cfg_index) == CFG_RATE);
    // oversized strip clamps to the maximum
    assign count_eff   = (r_pixel_count > MAX_PIXELS) ? MAX_PIXELS : r_pixel_count;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= MAX_PIXELS;
            r_rate        <= DEFAULT_RATE;
            r_color_red   <= '1;
            r_color_green <= '1;
            r_color_blue  <= '1;
            r_color_alpha <= '1;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[COUNT_W-1:0];
                CFG_RATE:        r_rate        <= i_cfg_data[RATE_W-1:0];
                CFG_COLOR_RED:   r_color_red   <= i_cfg_data[CHAN_W-1:0];
                CFG_COLOR_GREEN: r_color_green <= i_cfg_data[CHAN_W-1:0];
                CFG_COLOR_BLUE:  r_color_blue  <= i_cfg_data[CHAN_W-1:0];
                CFG_COLOR_ALPHA: r_color_alpha <= i_cfg_data[CHAN_W-1:0];
                default: ;   // unused indexes: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------- cycle length
    logic [LEN_W-1:0] cycle_len;

    lta_len_div u_len_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_recalc      (recalc),
        .i_pixel_count (count_eff),
        .i_rate        (r_rate),
        .o_busy        (busy),
        .o_cycle_len   (cycle_len)
    );

    // ------------------------------------------- s1: spread offset multiply
    logic              r_s1_vld;
    t_tag              r_s1_tag;
    logic [TIME_W-1:0] r_s1_time;
    logic [TIME_W-1:0] r_s1_offs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tag.idx      <= i_pixel_index;
            r_s1_tag.on_strip <= {1'b0, i_pixel_index} < count_eff;
            r_s1_time         <= i_frame_time;
            // wraps at 2^32
            r_s1_offs         <= TIME_W'(i_pixel_index) * SPREAD_PRIME;
        end
    end

    // --------------------------------------------------------- s2: time sum
    logic              r_s2_vld;
    t_tag              r_s2_tag;
    logic [TIME_W-1:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_tag <= r_s1_tag;
            r_s2_sum <= r_s1_time + r_s1_offs;
        end
    end

    // ------------------------------------------------ phase = sum mod cycle
    logic             mod_vld;
    t_tag             mod_tag;
    logic [LEN_W-1:0] mod_phase;

    lta_mod_pipe u_mod_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s2_vld),
        .i_tag      (r_s2_tag),
        .i_dividend (r_s2_sum),
        .i_len      (cycle_len),
        .o_valid    (mod_vld),
        .o_tag      (mod_tag),
        .o_phase    (mod_phase)
    );

    // ------------------------------------------------ s3: ramp select
    logic                r_s3_vld;
    logic [IDX_W-1:0]    r_s3_idx;
    logic                r_s3_lit;
    logic                r_s3_rise;
    logic [FACTOR_W-1:0] r_s3_factor;

    logic              rise;
    logic              in_ramp;
    logic [RAMP_W-1:0] fall_factor;

    assign rise        = mod_phase < LEN_W'(BRIGHTEN_MS);
    assign in_ramp     = mod_phase < LEN_W'(RAMP_END_MS);
    // only used inside the falling ramp, where it lies in 1..DIM_MS
    assign fall_factor = RAMP_W'(RAMP_END_MS) - mod_phase[RAMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= mod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_vld) begin
            r_s3_idx    <= mod_tag.idx;
            r_s3_lit    <= mod_tag.on_strip && in_ramp;
            r_s3_rise   <= rise;
            r_s3_factor <= rise ? mod_phase[FACTOR_W-1:0] : fall_factor[FACTOR_W-1:0];
        end
    end

    // ------------------------------------------------ s4: factor * alpha
    logic                r_s4_vld;
    logic [IDX_W-1:0]    r_s4_idx;
    logic                r_s4_lit;
    logic                r_s4_rise;
    logic [SCALED_W-1:0] r_s4_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_s4_idx    <= r_s3_idx;
            r_s4_lit    <= r_s3_lit;
            r_s4_rise   <= r_s3_rise;
            r_s4_scaled <= SCALED_W'(r_s3_factor) * SCALED_W'(r_color_alpha);
        end
    end

    // ------------------------------- s5: divide by ramp length (reciprocal)
    logic              r_s5_vld;
    logic [IDX_W-1:0]  r_s5_idx;
    logic              r_s5_lit;
    logic [WIDE_W-1:0] r_s5_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_vld) begin
            r_s5_idx  <= r_s4_idx;
            r_s5_lit  <= r_s4_lit;
            r_s5_prod <= WIDE_W'(r_s4_scaled) *
                         WIDE_W'(r_s4_rise ? RECIP_RISE : RECIP_FALL);
        end
    end

    // ------------------------------------------------ output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s5_vld;
        end
    end

    // unlit pixels carry zeros apart from the index
    always_ff @(posedge i_clk) begin
        if (r_s5_vld) begin
            o_pixel_out <= r_s5_idx;
            o_lit       <= r_s5_lit;
            o_out_red   <= r_s5_lit ? r_color_red   : '0;
            o_out_green <= r_s5_lit ? r_color_green : '0;
            o_out_blue  <= r_s5_lit ? r_color_blue  : '0;
            o_out_alpha <= r_s5_lit ? r_s5_prod[RECIP_SHIFT +: CHAN_W] : '0;
        end
    end

    // ------------------------------------------------ checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted pixel gave no result at the expected cycle");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !recalc) |=> !busy)
        else $error("busy raised without a count or rate transfer");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LED twinkle alpha block
// Drives pixel commands in random bursts under a series of register settings,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import lta_pkg::*;

    // cycles with no transfer of any kind before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // one pixel result as seen on the output ports
    typedef struct packed {
        logic [IDX_W-1:0]  pixel;
        logic              lit;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_twinkle_result;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the registers, works out the twinkle
    // alpha of each accepted pixel and queues it until the result turns up.
    // ------------------------------------------------------------------------
    class twinkle_scoreboard;
        logic [COUNT_W-1:0] count_reg;
        logic [RATE_W-1:0]  rate_reg;
        logic [CHAN_W-1:0]  red_reg;
        logic [CHAN_W-1:0]  green_reg;
        logic [CHAN_W-1:0]  blue_reg;
        logic [CHAN_W-1:0]  alpha_reg;
        t_twinkle_result    expected_q[$];
        int                 errors;

        function new();
            count_reg = 11'd1024;
            rate_reg  = 16'd300;
            red_reg   = 8'hFF;
            green_reg = 8'hFF;
            blue_reg  = 8'hFF;
            alpha_reg = 8'hFF;
            errors    = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PIXEL_COUNT: count_reg = data[COUNT_W-1:0];
                CFG_RATE:        rate_reg  = data[RATE_W-1:0];
                CFG_COLOR_RED:   red_reg   = data[CHAN_W-1:0];
                CFG_COLOR_GREEN: green_reg = data[CHAN_W-1:0];
                CFG_COLOR_BLUE:  blue_reg  = data[CHAN_W-1:0];
                CFG_COLOR_ALPHA: alpha_reg = data[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        // pixels on the strip once the oversize clamp is applied
        function logic [COUNT_W-1:0] strip_len();
            return (count_reg > MAX_PIXELS) ? MAX_PIXELS : count_reg;
        endfunction

        // twinkle period in ms, never below 1
        function longint unsigned cycle_ms();
            longint unsigned rate;
            longint unsigned len;
            rate = (rate_reg == '0) ? longint'(DEFAULT_RATE) : longint'(rate_reg);
            len  = (longint'(MS_PER_MINUTE) * longint'(strip_len())) / rate;
            return (len == 0) ? 1 : len;
        endfunction

        function void note_pixel(input logic [IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] t);
            t_twinkle_result   want;
            logic [TIME_W-1:0] sum;
            longint unsigned   phase;
            longint unsigned   alpha;
            want       = '0;
            want.pixel = idx;
            alpha      = 0;
            if (idx < strip_len()) begin
                sum   = t + 32'(idx) * SPREAD_PRIME;
                phase = longint'(sum) % cycle_ms();
                if (phase < BRIGHTEN_MS) begin
                    want.lit = 1'b1;
                    alpha    = (phase * alpha_reg) / BRIGHTEN_MS;
                end else if (phase < RAMP_END_MS) begin
                    want.lit = 1'b1;
                    alpha    = ((RAMP_END_MS - phase) * alpha_reg) / DIM_MS;
                end
            end
            if (want.lit) begin
                want.red   = red_reg;
                want.green = green_reg;
                want.blue  = blue_reg;
                want.alpha = alpha[CHAN_W-1:0];
            end
            expected_q.push_back(want);
        endfunction

        function void compare_field(input string name, input longint unsigned want,
                                    input longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(input t_twinkle_result got);
            t_twinkle_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result for pixel %0d, expected none",
                         $time, got.pixel);
                return;
            end
            want = expected_q.pop_front();
            compare_field("pixel_out", want.pixel, got.pixel);
            compare_field("lit",       want.lit,   got.lit);
            compare_field("out_red",   want.red,   got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue",  want.blue,  got.blue);
            compare_field("out_alpha", want.alpha, got.alpha);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT wiring
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [IDX_W-1:0]      i_pixel_index;
    logic [TIME_W-1:0]     i_frame_time;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [IDX_W-1:0]      o_pixel_out;
    logic                  o_lit;
    logic [CHAN_W-1:0]     o_out_red;
    logic [CHAN_W-1:0]     o_out_green;
    logic [CHAN_W-1:0]     o_out_blue;
    logic [CHAN_W-1:0]     o_out_alpha;

    twinkle_scoreboard sb;
    int                idle_cycles;
    int                burst_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    led_twinkle_alpha_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_index (i_pixel_index),
        .i_frame_time  (i_frame_time),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_pixel_out   (o_pixel_out),
        .o_lit         (o_lit),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha)
    );

    // ------------------------------------------------------------------------
    // Result side: the strobe cannot be held off, so every edge with o_done
    // high is a transfer. Values read here are the pre-edge ones.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result({o_pixel_out, o_lit, o_out_red, o_out_green,
                             o_out_blue, o_out_alpha});
    end

    // Watchdog: counts edges where nothing moved on any port
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("led_twinkle_alpha_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // frame time that puts a pixel's spread sum on a chosen value
    function automatic logic [TIME_W-1:0] time_for_sum(input logic [IDX_W-1:0] idx,
                                                      input logic [TIME_W-1:0] sum);
        return sum - 32'(idx) * SPREAD_PRIME;
    endfunction

    // sender pacing: bursts of back-to-back commands split by short gaps
    function automatic int next_gap(input bit steady);
        if (steady)
            return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(24, 1);
        return $urandom_range(12, 1);
    endfunction

    // one pixel command; start stays high on return so the next one can follow
    task automatic send_pixel(input logic [IDX_W-1:0] idx,
                              input logic [TIME_W-1:0] t, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_pixel_index <= idx;
        i_frame_time  <= t;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(idx, t);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    // drain the pipeline, then rewrite every register (upper data bits are
    // junk for the narrow ones and must be dropped)
    task automatic configure(input logic [CFG_DATA_W-1:0] count_w,
                             input logic [CFG_DATA_W-1:0] rate_w,
                             input logic [CFG_DATA_W-1:0] red_w,
                             input logic [CFG_DATA_W-1:0] green_w,
                             input logic [CFG_DATA_W-1:0] blue_w,
                             input logic [CFG_DATA_W-1:0] alpha_w);
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        cfg_write($urandom_range(1, 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  16'($urandom));
        cfg_write(CFG_COLOR_RED,   red_w);
        cfg_write(CFG_PIXEL_COUNT, count_w);
        cfg_write(CFG_COLOR_GREEN, green_w);
        cfg_write(CFG_RATE,        rate_w);
        cfg_write(CFG_COLOR_BLUE,  blue_w);
        cfg_write(CFG_COLOR_ALPHA, alpha_w);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [IDX_W-1:0]      idx;
        logic [TIME_W-1:0]     t;
        logic [CFG_DATA_W-1:0] count_w;
        logic [CFG_DATA_W-1:0] rate_w;
        logic [CFG_DATA_W-1:0] alpha_w;
        longint unsigned       len;
        longint unsigned       ph;
        longint unsigned       wraps;
        int                    strip;
        bit                    steady;

        sb            = new();
        idle_cycles   = 0;
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_pixel_index <= '0;
        i_frame_time  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PIXEL_COUNT;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset settings, 204800 ms period -----------------------
        // ramp start, mid rise, top of the rise, fall start and the ms after, ramp end, one past the end
        send_pixel(10'd0, time_for_sum(10'd0, 32'd0), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd50), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd99), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd100), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd101), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd1099), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd1100), 0);
        // last ms of one period and first of the next
        send_pixel(10'd0, time_for_sum(10'd0, 32'd204799), 0);
        send_pixel(10'd0, time_for_sum(10'd0, 32'd204800), 0);
        // spread sum wrapping past 2^32
        send_pixel(10'd1023, 32'hFFFF_FFFF, 0);
        send_pixel(10'd1, time_for_sum(10'd1, 32'd0), 0);
        send_pixel(10'd1023, time_for_sum(10'd1023, 32'd1024060), 0);
        send_pixel(10'd600, 32'd0, 0);

        // oversized strip and zero rate: same period as the defaults
        configure(16'h07FF, 16'h0000, 16'h00A5, 16'h005A, 16'h000F, 16'h00FF);
        send_pixel(10'd1023, time_for_sum(10'd1023, 32'd50), 0);
        send_pixel(10'd1023, time_for_sum(10'd1023, 32'd700), 0);
        send_pixel(10'd512, time_for_sum(10'd512, 32'd1099), 0);

        // short cycle: period floors to 0 and is forced to 1, phase always 0
        configure(16'h0001, 16'hFFFF, 16'h0000, 16'h00FF, 16'h0080, 16'h0080);
        send_pixel(10'd0, 32'($urandom), 0);
        send_pixel(10'd0, 32'd0, 0);
        send_pixel(10'd1, 32'd0, 0);              // off the strip
        send_pixel(10'd1023, 32'hFFFF_FFFF, 0);

        // empty strip: nothing can light; junk above the register widths
        configure(16'hF800, 16'h0001, 16'hFF12, 16'hAB34, 16'hCD56, 16'h77FF);
        send_pixel(10'd0, 32'd0, 0);
        send_pixel(10'd7, 32'd12345, 0);

        // --- random phases ----------------------------------------------------
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(7, 0))
                0:       count_w = {5'($urandom), 11'd0};
                1:       count_w = {5'($urandom), 11'd1};
                2:       count_w = {5'($urandom), 11'd1024};
                3:       count_w = {5'($urandom), 11'($urandom_range(2047, 1025))};
                default: count_w = {5'($urandom), 11'($urandom_range(1024, 1))};
            endcase
            case ($urandom_range(5, 0))
                0:       rate_w = 16'd0;
                1:       rate_w = 16'd1;
                2:       rate_w = 16'hFFFF;
                3:       rate_w = 16'($urandom);
                default: rate_w = 16'($urandom_range(3000, 1));
            endcase
            case ($urandom_range(3, 0))
                0:       alpha_w = {8'($urandom), 8'hFF};
                1:       alpha_w = {8'($urandom), 8'h00};
                default: alpha_w = 16'($urandom);
            endcase
            configure(count_w, rate_w, 16'($urandom), 16'($urandom),
                      16'($urandom), alpha_w);

            // every fourth phase streams with no gaps at all
            steady = (p % 4 == 3);
            strip  = int'(sb.strip_len());
            len    = sb.cycle_ms();
            for (int n = 0; n < 66; n++) begin
                if (strip != 0 && $urandom_range(4, 0) != 0)
                    idx = IDX_W'($urandom_range(strip - 1, 0));
                else
                    idx = IDX_W'($urandom_range(1023, 0));
                if ($urandom_range(99, 0) < 65) begin
                    // aim at a phase on or near the ramps, any period count
                    case ($urandom_range(3, 0))
                        0:       ph = $urandom_range(BRIGHTEN_MS - 1, 0);
                        1, 2:    ph = $urandom_range(RAMP_END_MS - 1, BRIGHTEN_MS);
                        default: ph = $urandom_range(RAMP_END_MS + 50,
                                                     BRIGHTEN_MS - 50);
                    endcase
                    ph    = ph % len;
                    wraps = (64'hFFFF_FFFF - ph) / len;
                    wraps = $urandom_range(32'(wraps), 0);
                    t     = time_for_sum(idx, 32'(wraps * len + ph));
                end else begin
                    t = $urandom;
                end
                send_pixel(idx, t, next_gap(steady));
            end
        end

        // --- drain and report -------------------------------------------------
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("led_twinkle_alpha_top verification clean");
        else
            $display("led_twinkle_alpha_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
design/lta_pkg.sv
design/lta_len_div.sv
design/lta_mod_pipe.sv
design/led_twinkle_alpha_top.sv
test/tb_top.sv
